// ===== sv/lpdz_pkg.sv =====
// Shared types and constants for the lidar point depth map core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package lpdz_pkg;

  localparam int DEF_MAX_WIDTH       = 2048;
  localparam int DEF_MAX_HEIGHT      = 512;
  localparam int DEF_COORD_FRAC_BITS = 10;

  localparam int COORD_W   = 18;  // point coordinate width
  localparam int COEF_W    = 32;  // Q16.16 matrix coefficient
  localparam int H_W       = 52;  // projected row sum
  localparam int SS_W      = 39;  // signed running sum of squares
  localparam int RAD_W     = 36;  // final sum of squares
  localparam int ROOT_W    = 18;  // square root of RAD_W bits
  localparam int WL_W      = 13;  // column bound, up to 4096
  localparam int HL_W      = 12;  // row bound, up to 2048
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_PROJ  = 6;
  localparam int CNT_W     = 6;

  localparam logic [CFG_IDX_W-1:0] REG_PROJ_C0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_C1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_C2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_C3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_C4      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROJ_C5      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd7;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_POINT = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_POINT,
    ST_READ,
    ST_READ_RES,
    ST_PT_READ,
    ST_PT_CMP
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MAC,
    PH_OFS,
    PH_ABS,
    PH_DIV,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic done;
    logic hit;
  } pt_stat_t;

endpackage
`default_nettype wire

// ===== sv/lpdz_point.sv =====
// Point datapath: bit-serial projection and squares, then serial division
// and serial square root. Depends on lpdz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lpdz_point import lpdz_pkg::*; #(
  parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int ROW_W  = $clog2(MAX_HEIGHT),
  localparam int LIM    = 30 * (2 ** COORD_FRAC_BITS),
  localparam int DIST_W = $clog2(LIM)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic signed [COORD_W-1:0]     px,
  input  wire logic signed [COORD_W-1:0]     py,
  input  wire logic signed [COORD_W-1:0]     pz,
  input  wire logic [NUM_PROJ-1:0][CFG_W-1:0] proj,
  input  wire logic [WL_W-1:0]               w_lim,
  input  wire logic [HL_W-1:0]               h_lim,
  output pt_stat_t                           stat,
  output logic [COL_W-1:0]                   col,
  output logic [ROW_W-1:0]                   row,
  output logic [DIST_W-1:0]                  dist_val
);

  phase_t phase, phase_next;
  logic [CNT_W-1:0] cnt;

  logic [COORD_W-1:0] xs, ys, zs;
  logic signed [COORD_W-1:0] xv, yv, zv;
  logic signed [H_W-1:0] acc [3];
  logic signed [SS_W-1:0] ss;

  logic s_neg_u, s_neg_v, h2_zero;
  logic [H_W-1:0] dvd_u, dvd_v, dsr;
  logic [H_W:0]   rem_u, rem_v;
  logic [RAD_W-1:0] nrad;
  logic [ROOT_W+2:0] srem;
  logic [ROOT_W-1:0] root;

  logic signed [COEF_W-1:0] m [3][4];
  logic signed [H_W-1:0] term [3];
  logic signed [SS_W-1:0] sq_term;
  logic [H_W:0] rsh_u, rsh_v;
  logic [ROOT_W+2:0] srem_sh, trial;
  logic u_ok, v_ok, d_ok;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = proj[r*2 + (c >> 1)][(c & 1)*COEF_W +: COEF_W];
      end
    end
  end

  // one bit of each coordinate per cycle, MSB first; the sign bit weighs negative
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      term[r] = (xs[COORD_W-1] ? H_W'(m[r][0]) : '0)
              + (ys[COORD_W-1] ? H_W'(m[r][1]) : '0)
              + (zs[COORD_W-1] ? H_W'(m[r][2]) : '0);
    end
    sq_term = (xs[COORD_W-1] ? SS_W'(xv) : '0)
            + (ys[COORD_W-1] ? SS_W'(yv) : '0)
            + (zs[COORD_W-1] ? SS_W'(zv) : '0);
  end

  assign rsh_u   = {rem_u[H_W-1:0], dvd_u[H_W-1]};
  assign rsh_v   = {rem_v[H_W-1:0], dvd_v[H_W-1]};
  assign srem_sh = {srem[ROOT_W:0], nrad[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: if (go) phase_next = PH_MAC;
      PH_MAC:  if (cnt == CNT_W'(COORD_W - 1)) phase_next = PH_OFS;
      PH_OFS:  phase_next = PH_ABS;
      PH_ABS:  phase_next = PH_DIV;
      PH_DIV:  if (cnt == CNT_W'(H_W - 1)) phase_next = PH_DONE;
      PH_DONE: phase_next = PH_IDLE;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    u_ok = !s_neg_u && (dvd_u != '0) && (dvd_u < H_W'(w_lim));
    v_ok = !s_neg_v && (dvd_v != '0) && (dvd_v < H_W'(h_lim));
    d_ok = (root != '0) && (32'(root) < LIM);
    stat.done = (phase == PH_DONE);
    stat.hit  = !h2_zero && u_ok && v_ok && d_ok;
    col      = dvd_u[COL_W-1:0];
    row      = dvd_v[ROW_W-1:0];
    dist_val = DIST_W'(root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      cnt   <= (phase_next != phase) ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        if (go) begin
          xs <= px;  ys <= py;  zs <= pz;
          xv <= px;  yv <= py;  zv <= pz;
          for (int r = 0; r < 3; r++) acc[r] <= '0;
          ss <= '0;
        end
      end
      PH_MAC: begin
        for (int r = 0; r < 3; r++) begin
          acc[r] <= (acc[r] <<< 1) + ((cnt == '0) ? -term[r] : term[r]);
        end
        ss <= (ss <<< 1) + ((cnt == '0) ? -sq_term : sq_term);
        xs <= xs << 1;
        ys <= ys << 1;
        zs <= zs << 1;
      end
      PH_OFS: begin
        for (int r = 0; r < 3; r++) begin
          acc[r] <= acc[r] + (H_W'(m[r][3]) <<< COORD_FRAC_BITS);
        end
      end
      PH_ABS: begin
        s_neg_u <= acc[0][H_W-1] ^ acc[2][H_W-1];
        s_neg_v <= acc[1][H_W-1] ^ acc[2][H_W-1];
        h2_zero <= (acc[2] == '0);
        dvd_u   <= acc[0][H_W-1] ? -acc[0] : acc[0];
        dvd_v   <= acc[1][H_W-1] ? -acc[1] : acc[1];
        dsr     <= acc[2][H_W-1] ? -acc[2] : acc[2];
        rem_u   <= '0;
        rem_v   <= '0;
        nrad    <= ss[RAD_W-1:0];
        srem    <= '0;
        root    <= '0;
      end
      PH_DIV: begin
        // restoring division, quotient bits shift into the dividend
        if (rsh_u >= {1'b0, dsr}) begin
          rem_u <= rsh_u - {1'b0, dsr};
          dvd_u <= {dvd_u[H_W-2:0], 1'b1};
        end else begin
          rem_u <= rsh_u;
          dvd_u <= {dvd_u[H_W-2:0], 1'b0};
        end
        if (rsh_v >= {1'b0, dsr}) begin
          rem_v <= rsh_v - {1'b0, dsr};
          dvd_v <= {dvd_v[H_W-2:0], 1'b1};
        end else begin
          rem_v <= rsh_v;
          dvd_v <= {dvd_v[H_W-2:0], 1'b0};
        end
        // square root, two radicand bits per step, alongside the division
        if (cnt < CNT_W'(ROOT_W)) begin
          nrad <= nrad << 2;
          if (srem_sh >= trial) begin
            srem <= srem_sh - trial;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            srem <= srem_sh;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/lidar_point_depth_zbuffer_core.sv =====
// Top level of the lidar point depth map: command port, configuration
// registers, depth memory and control. Depends on lpdz_pkg and lpdz_point.
`timescale 1ns / 1ps
`default_nettype none
//  channel   handshake             payload
//  command   start, busy           opcode, point_x/y/z, read_col, read_row
//  result    done (one cycle)      written, pixel_col, pixel_row, range_value,
//                                  pixel_empty
//  config    cfg_we                cfg_index, cfg_data
//
// A point with x > 0 runs the bit-serial projection and squares, then
// offset and magnitudes, then the one-bit-a-step division (the root runs
// alongside), then on a hit a memory read and a compare/write. A read in
// range takes a memory read; other points, out-of-range reads and the
// unused opcode leave busy low. A clear, and reset, sweep the memory one
// entry a cycle, busy high. Results cannot be stalled; done pulses once.
module lidar_point_depth_zbuffer_core import lpdz_pkg::*; #(
  parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                opcode,
  input  wire logic signed [COORD_W-1:0] point_x,
  input  wire logic signed [COORD_W-1:0] point_y,
  input  wire logic signed [COORD_W-1:0] point_z,
  input  wire logic [10:0]               read_col,
  input  wire logic [8:0]                read_row,
  output logic                           done,
  output logic                           written,
  output logic [10:0]                    pixel_col,
  output logic [8:0]                     pixel_row,
  output logic [14:0]                    range_value,
  output logic                           pixel_empty,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DIST_W  = $clog2(30 * (2 ** COORD_FRAC_BITS));
  localparam int ENTRY_W = DIST_W + 1;
  localparam int NPIX    = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(NPIX);

  logic [NUM_PROJ-1:0][CFG_W-1:0] proj;
  logic [11:0] image_width;
  logic [9:0]  image_height;
  logic [WL_W-1:0] w_lim;
  logic [HL_W-1:0] h_lim;

  state_t state, state_next;
  logic [ADDR_W-1:0] clr_cnt, addr, waddr;
  logic clr_report;
  logic [ENTRY_W-1:0] mem [NPIX];
  logic [ENTRY_W-1:0] rd_data, wdata;
  logic mem_we;

  logic [10:0] rcol;
  logic [8:0]  rrow;
  logic [COL_W-1:0]  pcol;
  logic [ROW_W-1:0]  prow;
  logic [DIST_W-1:0] pdist;

  pt_stat_t pt_stat;
  logic [COL_W-1:0]  pt_col;
  logic [ROW_W-1:0]  pt_row;
  logic [DIST_W-1:0] pt_dist;

  logic accept, x_pos, in_store, go, last_clr, better;
  logic done_next, written_next, empty_next;
  logic [10:0] col_next;
  logic [8:0]  row_next;
  logic [14:0] range_next;

  assign accept   = start && !busy;
  assign x_pos    = !point_x[COORD_W-1] && (point_x != '0);
  assign in_store = (32'(read_col) < MAX_WIDTH) && (32'(read_row) < MAX_HEIGHT);
  assign last_clr = (clr_cnt == ADDR_W'(NPIX - 1));
  assign better   = !rd_data[ENTRY_W-1] || (rd_data[DIST_W-1:0] > pdist);
  assign busy     = (state != ST_IDLE);

  always_comb begin
    w_lim = (32'(image_width) < MAX_WIDTH) ? WL_W'(image_width) : WL_W'(MAX_WIDTH);
    h_lim = (32'(image_height) < MAX_HEIGHT) ? HL_W'(image_height) : HL_W'(MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proj         <= '0;
      image_width  <= 12'd2048;
      image_height <= 10'd512;
    end else if (cfg_we) begin
      if (cfg_index < REG_IMAGE_WIDTH) proj[cfg_index] <= cfg_data;
      else if (cfg_index == REG_IMAGE_WIDTH) image_width <= cfg_data[11:0];
      else image_height <= cfg_data[9:0];
    end
  end

  lpdz_point #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_point (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .px       (point_x),
    .py       (point_y),
    .pz       (point_z),
    .proj     (proj),
    .w_lim    (w_lim),
    .h_lim    (h_lim),
    .stat     (pt_stat),
    .col      (pt_col),
    .row      (pt_row),
    .dist_val (pt_dist)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_t'(opcode))
            OP_CLEAR: state_next = ST_CLEAR;
            OP_POINT: if (x_pos) state_next = ST_POINT;
            OP_READ:  if (in_store) state_next = ST_READ;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:    if (last_clr) state_next = ST_IDLE;
      ST_POINT:    if (pt_stat.done) state_next = pt_stat.hit ? ST_PT_READ : ST_IDLE;
      ST_PT_READ:  state_next = ST_PT_CMP;
      ST_PT_CMP:   state_next = ST_IDLE;
      ST_READ:     state_next = ST_READ_RES;
      ST_READ_RES: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    done_next    = 1'b0;
    written_next = 1'b0;
    col_next     = '0;
    row_next     = '0;
    range_next   = '0;
    empty_next   = 1'b0;
    mem_we       = 1'b0;
    waddr        = addr;
    wdata        = '0;
    go           = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_t'(opcode))
            OP_CLEAR: begin
            end
            OP_POINT: begin
              go        = x_pos;
              done_next = !x_pos;
            end
            OP_READ: begin
              if (!in_store) begin
                done_next  = 1'b1;
                col_next   = read_col;
                row_next   = read_row;
                empty_next = 1'b1;
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        waddr     = clr_cnt;
        done_next = last_clr && clr_report;
      end
      ST_POINT: done_next = pt_stat.done && !pt_stat.hit;
      ST_PT_CMP: begin
        done_next = 1'b1;
        if (better) begin
          mem_we       = 1'b1;
          wdata        = {1'b1, pdist};
          written_next = 1'b1;
          col_next     = 11'(pcol);
          row_next     = 9'(prow);
          range_next   = 15'(pdist);
        end
      end
      ST_READ_RES: begin
        done_next = 1'b1;
        col_next  = rcol;
        row_next  = rrow;
        if (rd_data[ENTRY_W-1]) range_next = 15'(rd_data[DIST_W-1:0]);
        else empty_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_IDLE && accept && opcode_t'(opcode) == OP_CLEAR) begin
        clr_cnt    <= '0;
        clr_report <= 1'b1;
      end
    end
  end

  // result and operand holding registers
  always_ff @(posedge clk) begin
    written     <= written_next;
    pixel_col   <= col_next;
    pixel_row   <= row_next;
    range_value <= range_next;
    pixel_empty <= empty_next;
    if (state == ST_IDLE && accept) begin
      rcol <= read_col;
      rrow <= read_row;
      addr <= ADDR_W'(32'(read_row) * MAX_WIDTH + 32'(read_col));
    end
    if (state == ST_POINT && pt_stat.done) begin
      pcol  <= pt_col;
      prow  <= pt_row;
      pdist <= pt_dist;
      addr  <= ADDR_W'(32'(pt_row) * MAX_WIDTH + 32'(pt_col));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_data <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== sim/depth_map_checker.sv =====
// Scoreboard for the lidar point depth map core: watches the config port,
// predicts each command beat and compares result beats. Depends on lpdz_pkg.
`timescale 1ns / 1ps
module depth_map_checker import lpdz_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                opcode,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic [10:0]               read_col,
  input  logic [8:0]                read_row,
  input  logic                      done,
  input  logic                      written,
  input  logic [10:0]               pixel_col,
  input  logic [8:0]                pixel_row,
  input  logic [14:0]               range_value,
  input  logic                      pixel_empty,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic        written;
    logic [10:0] col;
    logic [8:0]  row;
    logic [14:0] range;
    logic        empty;
  } depth_result_t;

  localparam longint RANGE_LIMIT = 30 << DEF_COORD_FRAC_BITS;

  logic [CFG_W-1:0] matrix_regs [NUM_PROJ];
  logic [11:0]      width_reg;
  logic [9:0]       height_reg;
  int unsigned      nearest_range [int unsigned];
  depth_result_t    expected_beats [$];

  assign pending = expected_beats.size();

  function automatic longint coef(int r, int c);
    logic [CFG_W-1:0] w;
    w = matrix_regs[r * 2 + c / 2];
    return (c % 2) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
  endfunction

  function automatic longint project_row(int r, longint x, longint y, longint z);
    return coef(r, 0) * x + coef(r, 1) * y + coef(r, 2) * z
         + coef(r, 3) * (longint'(1) << DEF_COORD_FRAC_BITS);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic depth_result_t predict_depth_beat();
    depth_result_t res;
    longint x, y, z, h2, u, v, wl, hl;
    longint unsigned d;
    int unsigned addr;
    res = '0;
    x = point_x;
    y = point_y;
    z = point_z;
    case (opcode_t'(opcode))
      OP_CLEAR: nearest_range.delete();
      OP_POINT: begin
        if (x > 0) begin
          h2 = project_row(2, x, y, z);
          if (h2 != 0) begin
            u  = project_row(0, x, y, z) / h2;
            v  = project_row(1, x, y, z) / h2;
            d  = root_floor(longint'(x * x + y * y + z * z));
            wl = (width_reg < DEF_MAX_WIDTH) ? width_reg : DEF_MAX_WIDTH;
            hl = (height_reg < DEF_MAX_HEIGHT) ? height_reg : DEF_MAX_HEIGHT;
            if (d > 0 && d < RANGE_LIMIT && u > 0 && u < wl && v > 0 && v < hl) begin
              addr = int'(v) * DEF_MAX_WIDTH + int'(u);
              if (!nearest_range.exists(addr) || nearest_range[addr] > d) begin
                nearest_range[addr] = int'(d);
                res.written = 1'b1;
                res.col     = u[10:0];
                res.row     = v[8:0];
                res.range   = d[14:0];
              end
            end
          end
        end
      end
      OP_READ: begin
        res.col = read_col;
        res.row = read_row;
        addr = read_row * DEF_MAX_WIDTH + read_col;
        if (read_col < DEF_MAX_WIDTH && read_row < DEF_MAX_HEIGHT &&
            nearest_range.exists(addr)) begin
          res.range = nearest_range[addr][14:0];
        end else begin
          res.empty = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    depth_result_t got, exp;
    if (rst) begin
      foreach (matrix_regs[i]) matrix_regs[i] = '0;
      width_reg  = 12'd2048;
      height_reg = 10'd512;
      nearest_range.delete();
      expected_beats.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index < NUM_PROJ) matrix_regs[cfg_index] = cfg_data;
        else if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data[11:0];
        else if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_data[9:0];
      end
      if (done) begin
        got = '{written, pixel_col, pixel_row, range_value, pixel_empty};
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          fail_count++;
        end else begin
          exp = expected_beats.pop_front();
          if (got !== exp) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp, got);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_beats.insert(expected_beats.size(), predict_depth_beat());
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the depth map regression: clock, reset, command and config stimulus,
// verdict. Depends on lpdz_pkg, depth_map_checker and the core.
`timescale 1ns / 1ps
module testbench;
  import lpdz_pkg::*;

  localparam int CYCLE_LIMIT  = 16_000_000;
  localparam int PHASE_ITEMS  = 118;
  localparam int NUM_PHASES   = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] opcode = OP_NONE;
  logic signed [COORD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic [10:0] read_col = '0;
  logic [8:0]  read_row = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic busy, done, written, pixel_empty;
  logic [10:0] pixel_col;
  logic [8:0]  pixel_row;
  logic [14:0] range_value;
  int fail_count, pending;
  int cycles = 0;
  int idle_pct = 0;
  logic [19:0] hit_log [$];
  int base_x, base_y, base_z;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lidar_point_depth_zbuffer_core u_dut (
    .clk, .rst, .start, .busy, .opcode, .point_x, .point_y, .point_z,
    .read_col, .read_row, .done, .written, .pixel_col, .pixel_row,
    .range_value, .pixel_empty, .cfg_we, .cfg_index, .cfg_data
  );

  depth_map_checker u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    // remember written pixels so reads can hit them
    if (done && written) begin
      hit_log.insert(hit_log.size(), {pixel_row, pixel_col});
      if (hit_log.size() > 64) void'(hit_log.pop_front());
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("lidar_point_depth_zbuffer_core regression: fail");
      $finish;
    end
  end

  task automatic send_cmd(opcode_t op, int x, int y, int z, int c, int r);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start    = 1'b1;
    opcode   = op;
    point_x  = COORD_W'(x);
    point_y  = COORD_W'(y);
    point_z  = COORD_W'(z);
    read_col = 11'(c);
    read_row = 9'(r);
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // u = cx + f*y/x, v = cy + f*z/x, plus a column offset term
  task automatic set_camera(int cx, int cy, int f, int ofs);
    cfg_write(REG_PROJ_C0, {32'(f << 16), 32'(cx << 16)});
    cfg_write(REG_PROJ_C1, {32'(ofs), 32'd0});
    cfg_write(REG_PROJ_C2, {32'd0, 32'(cy << 16)});
    cfg_write(REG_PROJ_C3, {32'd0, 32'(f << 16)});
    cfg_write(REG_PROJ_C4, {32'd0, 32'h0001_0000});
    cfg_write(REG_PROJ_C5, 64'd0);
  endtask

  task automatic random_item(bit allow_clear);
    int k, sel;
    logic [19:0] px;
    sel = $urandom_range(99);
    if (allow_clear && sel == 0) begin
      send_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
    end else if (sel < 45) begin
      base_x = $urandom_range(7000, 256);
      base_y = int'($urandom_range(base_x)) - base_x / 2;
      base_z = int'($urandom_range(base_x)) - base_x / 2;
      send_cmd(OP_POINT, base_x, base_y, base_z, 0, 0);
    end else if (sel < 70) begin
      // same ray, range scaled by k: aims at the same pixel, nearer or farther
      k = $urandom_range(4, 1);
      send_cmd(OP_POINT, base_x * k, base_y * k, base_z * k, 0, 0);
    end else if (sel < 88) begin
      if (hit_log.size() != 0 && $urandom_range(1)) begin
        px = hit_log[$urandom_range(hit_log.size() - 1)];
        send_cmd(OP_READ, 0, 0, 0, int'(px[10:0]), int'(px[19:11]));
      end else begin
        send_cmd(OP_READ, 0, 0, 0, $urandom_range(2047), $urandom_range(511));
      end
    end else begin
      sel = $urandom_range(2);
      send_cmd(sel == 0 ? OP_NONE : (sel == 1 ? OP_POINT : OP_READ),
               $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int widths [NUM_PHASES] = '{2048, 0, 1, 4095, 1500, 2048, 700, 2048};
    int heights [NUM_PHASES] = '{512, 512, 1023, 0, 1, 300, 512, 1023};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset matrix is zero, so points see a zero divisor
    send_cmd(OP_READ, 0, 0, 0, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 2047, 511);
    send_cmd(OP_NONE, -1, -1, -1, 2047, 511);
    send_cmd(OP_POINT, 1000, 0, 0, 0, 0);
    wait_quiet();
    set_camera(1000, 250, 64, 0);
    cfg_write(REG_IMAGE_WIDTH, 64'd2048);
    cfg_write(REG_IMAGE_HEIGHT, 64'd512);
    send_cmd(OP_POINT, 10240, 0, 0, 0, 0);
    send_cmd(OP_POINT, 20480, 0, 0, 0, 0);
    send_cmd(OP_POINT, 5120, 0, 0, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 1000, 250);
    send_cmd(OP_POINT, -5, 10, 10, 0, 0);
    send_cmd(OP_POINT, 0, 0, 0, 0, 0);
    send_cmd(OP_POINT, 131071, 0, 0, 0, 0);
    send_cmd(OP_POINT, 30720, 0, 0, 0, 0);
    send_cmd(OP_POINT, 30719, 0, 0, 0, 0);
    send_cmd(OP_POINT, 1, 0, 0, 0, 0);
    send_cmd(OP_POINT, 1024, -16000, 0, 0, 0);
    send_cmd(OP_POINT, 131071, 131071, 131071, 0, 0);
    send_cmd(OP_POINT, 1024, -131072, -131072, 0, 0);
    send_cmd(OP_POINT, 4096, 1000, -900, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 1000, 250);
    send_cmd(OP_CLEAR, 0, 0, 0, 0, 0);
    send_cmd(OP_READ, 0, 0, 0, 1000, 250);
    wait_quiet();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 55 : 27);
      if (p == 5) begin
        for (int i = 0; i < NUM_PROJ; i++) cfg_write(CFG_IDX_W'(i), {$urandom, $urandom});
      end else begin
        set_camera($urandom_range(1100, 900), $urandom_range(300, 200),
                   $urandom_range(200, 16), int'($urandom_range(2000)) - 1000);
      end
      cfg_write(REG_IMAGE_WIDTH, 64'(widths[p]));
      cfg_write(REG_IMAGE_HEIGHT, 64'(heights[p]));
      base_x = 1024;
      base_y = 0;
      base_z = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) random_item(p == 4 && i == 60);
      wait_quiet();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("lidar_point_depth_zbuffer_core regression: pass");
    end else begin
      $display("lidar_point_depth_zbuffer_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lpdz_pkg.sv
sv/lpdz_point.sv
sv/lidar_point_depth_zbuffer_core.sv
sim/depth_map_checker.sv
sim/testbench.sv
